// ===== src/bthal_pkg.sv =====
// shared types, codes and defaults of the boundary tag heap allocator
package bthal_pkg;

  localparam int HEAP_UNITS_DEFAULT   = 4096;
  localparam int ALIGN_BYTES_DEFAULT  = 8;
  localparam int HEADER_UNITS_DEFAULT = 1;
  localparam int FOOTER_UNITS_DEFAULT = 1;
  localparam int TAG_W_DEFAULT        = 15;

  localparam logic [1:0] TAG_MARKER = 2'd2;

  localparam logic REG_HEAP_BASE   = 1'b0;
  localparam logic REG_HEAP_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    OP_FORMAT  = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CHECK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_IGNORED = 2'd2,
    ST_CORRUPT = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    C_NOP       = 5'd0,
    C_LATCH     = 5'd1,
    C_DIV_LO    = 5'd2,
    C_DIV_HI    = 5'd3,
    C_DIV_REQ   = 5'd4,
    C_DIV_OFF   = 5'd5,
    C_SAVE_QA   = 5'd6,
    C_SAVE_QB   = 5'd7,
    C_FMT_CLIP  = 5'd8,
    C_FMT_UNITS = 5'd9,
    C_FMT_SET   = 5'd10,
    C_WR_HEAD   = 5'd11,
    C_WR_FOOT   = 5'd12,
    C_WR_TAKE   = 5'd13,
    C_BLK_REST  = 5'd14,
    C_BLK_USED  = 5'd15,
    C_BLK_MERGE = 5'd16,
    C_RD_P      = 5'd17,
    C_RD_FOOT   = 5'd18,
    C_RD_PF     = 5'd19,
    C_RD_NH     = 5'd20,
    C_TAG       = 5'd21,
    C_ADV       = 5'd22,
    C_REL_INIT  = 5'd23,
    C_REL_HDR   = 5'd24,
    C_REL_PH    = 5'd25,
    C_REL_MP    = 5'd26,
    C_REL_MN    = 5'd27,
    C_FINISH    = 5'd28
  } cmd_t;

  typedef struct packed {
    cmd_t    cmd;
    status_t st;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic div_busy;
    logic fmt_small;
    logic need_gt_n;
    logic p_ge_n;
    logic fit;
    logic ext_bad;
    logic whole;
    logic rel_out;
    logic rem_nz;
    logic u_lt_h;
    logic hp_ge_n;
    logic foot_bad;
    logic tags_bad;
    logic h_free;
    logic p_zero;
    logic p_lt_f;
    logic pf_bad;
    logic rd_free;
    logic nh_lt_n;
    logic merge_bad;
  } flags_t;

endpackage

// ===== src/boundary_tag_heap_allocator_top.sv =====
// one item in flight; the next is taken in the idle cycle after the result beat is registered
// format stops early when the heap is too small, release when the address is outside the heap,
// allocate walks the blocks until one fits or none is left, check until the end or a bad tag;
// the single registered read port of the tag ram sets the walk rate
// a held result beat blocks only the next item's final cycle; alignment is a power of two
// synchronous reset clears control state and the heap bounds; the tag ram is not cleared
module boundary_tag_heap_allocator_top import bthal_pkg::*; #(
  parameter int HEAP_UNITS   = HEAP_UNITS_DEFAULT,
  parameter int ALIGN_BYTES  = ALIGN_BYTES_DEFAULT,
  parameter int HEADER_UNITS = HEADER_UNITS_DEFAULT,
  parameter int FOOTER_UNITS = FOOTER_UNITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] request_bytes,
  input  logic [31:0] release_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] payload_address,
  output status_t     status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctl_t   ctl;
  flags_t flags;

  assign pready = 1'b1;

  bthal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .ctl       (ctl)
  );

  bthal_dp #(
    .HEAP_UNITS   (HEAP_UNITS),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .HEADER_UNITS (HEADER_UNITS),
    .FOOTER_UNITS (FOOTER_UNITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .flags           (flags),
    .operation       (operation),
    .request_bytes   (request_bytes),
    .release_address (release_address),
    .payload_address (payload_address),
    .status          (status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule

// ===== src/bthal_ram.sv =====
// generic single write port ram with registered read
module bthal_ram import bthal_pkg::*; #(
  parameter int WIDTH = TAG_W_DEFAULT,
  parameter int DEPTH = HEAP_UNITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bthal_div.sv =====
// divider by a constant power of two: shift and low-bit test, result registered when start is high
module bthal_div import bthal_pkg::*; #(
  parameter int DIVISOR = ALIGN_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  output logic        busy,
  output logic [32:0] quotient,
  output logic        rem_nonzero
);

  localparam int          SH       = $clog2(DIVISOR);
  localparam logic [32:0] LOW_MASK = 33'(DIVISOR - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient    <= dividend >> SH;
      rem_nonzero <= |(dividend & LOW_MASK);
    end
  end

endmodule

// ===== src/bthal_dp.sv =====
// datapath: config registers, heap bounds, walk registers, tag ram and divider
module bthal_dp import bthal_pkg::*; #(
  parameter int HEAP_UNITS   = HEAP_UNITS_DEFAULT,
  parameter int ALIGN_BYTES  = ALIGN_BYTES_DEFAULT,
  parameter int HEADER_UNITS = HEADER_UNITS_DEFAULT,
  parameter int FOOTER_UNITS = FOOTER_UNITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output flags_t      flags,
  input  logic [1:0]  operation,
  input  logic [31:0] request_bytes,
  input  logic [31:0] release_address,
  output logic [31:0] payload_address,
  output status_t     status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata
);

  localparam int AW = $clog2(HEAP_UNITS);
  localparam int SW = AW;
  localparam int TW = SW + 3;
  localparam int NW = AW + 1;
  localparam int WW = AW + 4;
  localparam int MW = $clog2(ALIGN_BYTES + 1);
  localparam int PW = WW + MW;
  localparam logic [32:0]   LIMQ  = 33'(32'hFFFF_FFFF / ALIGN_BYTES);
  localparam logic [32:0]   UMAX  = 33'(HEAP_UNITS);
  localparam logic [32:0]   ALGN  = 33'(ALIGN_BYTES);
  localparam logic [WW-1:0] HDR   = WW'(HEADER_UNITS);
  localparam logic [WW-1:0] FTR   = WW'(FOOTER_UNITS);
  localparam logic [WW-1:0] TAGS  = WW'(HEADER_UNITS + FOOTER_UNITS);

  logic [31:0]   cfg_base, cfg_len, heap_start, heap_end;
  logic [NW-1:0] n_units;
  op_t           op_q;
  logic [31:0]   req_q, addr_q;
  logic [32:0]   qa, qb;
  logic          rnz;
  logic [WW-1:0] p, pf, nh, from, total;
  logic          wfree;
  logic [TW-1:0] tag_h, rd;

  logic [WW-1:0] nw, size_h, size_r, foot_r, foot_w;
  logic [32:0]   n33, start_prod, end_prod, div_in, div_q;
  logic [SW-1:0] blk_size;
  logic [PW-1:0] pay_off;
  logic          div_start, div_busy, div_rnz, we;
  logic [AW-1:0] waddr, raddr;
  logic [TW-1:0] wdata;

  assign nw         = WW'(n_units);
  assign n33        = 33'(n_units);
  assign size_h     = WW'(tag_h[SW-1:0]);
  assign size_r     = WW'(rd[SW-1:0]);
  assign foot_r     = p + HDR + size_h;
  assign foot_w     = from + total - FTR;
  assign blk_size   = SW'(total - TAGS);
  assign start_prod = qa * ALGN;
  assign end_prod   = (qa + qb) * ALGN;
  assign pay_off    = PW'(p + HDR) * PW'(ALIGN_BYTES);

  assign flags.op        = op_q;
  assign flags.div_busy  = div_busy;
  assign flags.fmt_small = qb < 33'(TAGS);
  assign flags.need_gt_n = qa > n33;
  assign flags.p_ge_n    = p >= nw;
  assign flags.fit       = tag_h[SW] && (33'(size_h) >= qa);
  assign flags.ext_bad   = (p + size_h + TAGS) > nw;
  assign flags.whole     = (33'(size_h) - qa) < 33'(TAGS);
  assign flags.rel_out   = (addr_q <= heap_start) || (addr_q > heap_end);
  assign flags.rem_nz    = rnz;
  assign flags.u_lt_h    = qa < 33'(HEADER_UNITS);
  assign flags.hp_ge_n   = (qa - 33'(HEADER_UNITS)) >= n33;
  assign flags.foot_bad  = (foot_r + FTR) > nw;
  assign flags.tags_bad  = (tag_h[TW-1:SW+1] != TAG_MARKER) || (rd[TW-1:SW+1] != TAG_MARKER) ||
                           (tag_h[SW-1:0] != rd[SW-1:0]);
  assign flags.h_free    = tag_h[SW];
  assign flags.p_zero    = p == '0;
  assign flags.p_lt_f    = p < FTR;
  assign flags.pf_bad    = pf < (size_r + HDR);
  assign flags.rd_free   = rd[SW];
  assign flags.nh_lt_n   = nh < nw;
  assign flags.merge_bad = (from + total) > nw;

  // divider operand select
  always_comb begin
    div_start = 1'b1;
    div_in    = 33'(cfg_base);
    case (ctl.cmd)
      C_DIV_LO:  div_in = 33'(cfg_base);
      C_DIV_HI:  div_in = 33'(cfg_base) + 33'(cfg_len);
      C_DIV_REQ: div_in = 33'(req_q) + 33'(ALIGN_BYTES - 1);
      C_DIV_OFF: div_in = 33'(addr_q - heap_start);
      default:   div_start = 1'b0;
    endcase
  end

  // tag ram port select
  always_comb begin
    we    = 1'b0;
    waddr = from[AW-1:0];
    wdata = {TAG_MARKER, wfree, blk_size};
    raddr = p[AW-1:0];
    case (ctl.cmd)
      C_WR_HEAD: we = 1'b1;
      C_WR_FOOT: begin
        we    = 1'b1;
        waddr = foot_w[AW-1:0];
        wdata = {TAG_MARKER, 1'b0, blk_size};
      end
      C_WR_TAKE: begin
        we    = 1'b1;
        waddr = p[AW-1:0];
        wdata = {tag_h[TW-1:SW+1], 1'b0, tag_h[SW-1:0]};
      end
      C_RD_FOOT: raddr = foot_r[AW-1:0];
      C_RD_PF:   raddr = pf[AW-1:0];
      C_RD_NH:   raddr = nh[AW-1:0];
      default:   raddr = p[AW-1:0];
    endcase
  end

  bthal_ram #(
    .WIDTH (TW),
    .DEPTH (HEAP_UNITS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  bthal_div #(
    .DIVISOR (ALIGN_BYTES)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend    (div_in),
    .busy        (div_busy),
    .quotient    (div_q),
    .rem_nonzero (div_rnz)
  );

  assign prdata = (paddr[2] == REG_HEAP_LENGTH) ? cfg_len : cfg_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base   <= '0;
      cfg_len    <= '0;
      heap_start <= '0;
      heap_end   <= '0;
      n_units    <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_HEAP_BASE:   cfg_base <= pwdata;
          REG_HEAP_LENGTH: cfg_len  <= pwdata;
          default:         cfg_base <= cfg_base;
        endcase
      end
      if (ctl.cmd == C_FMT_SET) begin
        heap_start <= start_prod[31:0];
        if (flags.fmt_small) begin
          heap_end <= start_prod[31:0];
          n_units  <= '0;
        end else begin
          heap_end <= end_prod[31:0];
          n_units  <= qb[NW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      C_LATCH: begin
        op_q   <= op_t'(operation);
        req_q  <= request_bytes;
        addr_q <= release_address;
        p      <= '0;
      end
      C_SAVE_QA: begin
        qa  <= div_q;
        rnz <= div_rnz;
      end
      C_SAVE_QB:  qb <= div_q;
      C_FMT_CLIP: begin
        qa <= ((qa + 33'(rnz)) > LIMQ) ? LIMQ : qa + 33'(rnz);
        qb <= (qb > LIMQ) ? LIMQ : qb;
      end
      C_FMT_UNITS: begin
        if (qb > qa) begin
          qb <= ((qb - qa) > UMAX) ? UMAX : qb - qa;
        end else begin
          qb <= '0;
        end
      end
      C_FMT_SET: begin
        from  <= '0;
        total <= WW'(qb);
        wfree <= 1'b1;
      end
      C_BLK_REST: begin
        from  <= p + WW'(qa) + TAGS;
        total <= size_h - WW'(qa);
        wfree <= 1'b1;
      end
      C_BLK_USED: begin
        from  <= p;
        total <= WW'(qa) + TAGS;
        wfree <= 1'b0;
      end
      C_BLK_MERGE: wfree <= 1'b1;
      C_TAG:       tag_h <= rd;
      C_ADV:       p <= p + size_h + TAGS;
      C_REL_INIT:  p <= WW'(qa - 33'(HEADER_UNITS));
      C_REL_HDR: begin
        total <= size_h + TAGS;
        from  <= p;
        nh    <= p + size_h + TAGS;
        pf    <= p - FTR;
      end
      C_REL_PH: pf <= pf - size_r - HDR;
      C_REL_MP: begin
        from  <= pf;
        total <= total + size_r + TAGS;
      end
      C_REL_MN: total <= total + size_r + TAGS;
      C_FINISH: begin
        status          <= ctl.st;
        payload_address <= (ctl.st == ST_DONE && op_q == OP_ALLOC) ?
                           heap_start + 32'(pay_off) : '0;
      end
      default: p <= p;
    endcase
  end

endmodule

// ===== src/bthal_ctrl.sv =====
// controller: sequences format, allocate, release and check over the datapath
module bthal_ctrl import bthal_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  output logic   out_valid,
  input  logic   out_stall,
  input  flags_t flags,
  output ctl_t   ctl
);

  typedef enum logic [39:0] {
    S_IDLE    = 40'd1 << 0,
    S_DISP    = 40'd1 << 1,
    S_F_WLO   = 40'd1 << 2,
    S_F_DHI   = 40'd1 << 3,
    S_F_WHI   = 40'd1 << 4,
    S_F_CLIP  = 40'd1 << 5,
    S_F_UNITS = 40'd1 << 6,
    S_F_SET   = 40'd1 << 7,
    S_F_WH    = 40'd1 << 8,
    S_F_WF    = 40'd1 << 9,
    S_A_WAIT  = 40'd1 << 10,
    S_A_CHK   = 40'd1 << 11,
    S_A_LOOP  = 40'd1 << 12,
    S_A_TAG   = 40'd1 << 13,
    S_A_EVAL  = 40'd1 << 14,
    S_A_W1    = 40'd1 << 15,
    S_A_W2    = 40'd1 << 16,
    S_A_W3    = 40'd1 << 17,
    S_A_W4    = 40'd1 << 18,
    S_A_W5    = 40'd1 << 19,
    S_R_WAIT  = 40'd1 << 20,
    S_R_U     = 40'd1 << 21,
    S_R_RDH   = 40'd1 << 22,
    S_R_TAG   = 40'd1 << 23,
    S_R_FT    = 40'd1 << 24,
    S_R_CMP   = 40'd1 << 25,
    S_R_PREV  = 40'd1 << 26,
    S_R_PFT   = 40'd1 << 27,
    S_R_PHR   = 40'd1 << 28,
    S_R_PHT   = 40'd1 << 29,
    S_R_NEXT  = 40'd1 << 30,
    S_R_NHT   = 40'd1 << 31,
    S_R_FIN   = 40'd1 << 32,
    S_R_WH    = 40'd1 << 33,
    S_R_WF    = 40'd1 << 34,
    S_C_LOOP  = 40'd1 << 35,
    S_C_TAG   = 40'd1 << 36,
    S_C_FT    = 40'd1 << 37,
    S_C_CMP   = 40'd1 << 38,
    S_FIN     = 40'd1 << 39
  } state_t;

  state_t  state, state_next;
  status_t fin_st, fin_st_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next  = state;
    fin_st_next = fin_st;
    ctl.cmd     = C_NOP;
    ctl.st      = fin_st;
    unique case (state)
      S_IDLE: if (in_valid) begin
        ctl.cmd    = C_LATCH;
        state_next = S_DISP;
      end
      S_DISP: begin
        unique case (flags.op)
          OP_FORMAT: begin
            ctl.cmd    = C_DIV_LO;
            state_next = S_F_WLO;
          end
          OP_ALLOC: begin
            ctl.cmd    = C_DIV_REQ;
            state_next = S_A_WAIT;
          end
          OP_RELEASE: if (flags.rel_out) begin
            state_next  = S_FIN;
            fin_st_next = ST_IGNORED;
          end else begin
            ctl.cmd    = C_DIV_OFF;
            state_next = S_R_WAIT;
          end
          OP_CHECK: state_next = S_C_LOOP;
        endcase
      end
      // format
      S_F_WLO: if (!flags.div_busy) begin
        ctl.cmd    = C_SAVE_QA;
        state_next = S_F_DHI;
      end
      S_F_DHI: begin
        ctl.cmd    = C_DIV_HI;
        state_next = S_F_WHI;
      end
      S_F_WHI: if (!flags.div_busy) begin
        ctl.cmd    = C_SAVE_QB;
        state_next = S_F_CLIP;
      end
      S_F_CLIP: begin
        ctl.cmd    = C_FMT_CLIP;
        state_next = S_F_UNITS;
      end
      S_F_UNITS: begin
        ctl.cmd    = C_FMT_UNITS;
        state_next = S_F_SET;
      end
      S_F_SET: begin
        ctl.cmd = C_FMT_SET;
        if (flags.fmt_small) begin
          state_next  = S_FIN;
          fin_st_next = ST_IGNORED;
        end else begin
          state_next = S_F_WH;
        end
      end
      S_F_WH: begin
        ctl.cmd    = C_WR_HEAD;
        state_next = S_F_WF;
      end
      S_F_WF: begin
        ctl.cmd     = C_WR_FOOT;
        state_next  = S_FIN;
        fin_st_next = ST_DONE;
      end
      // allocate
      S_A_WAIT: if (!flags.div_busy) begin
        ctl.cmd    = C_SAVE_QA;
        state_next = S_A_CHK;
      end
      S_A_CHK: if (flags.need_gt_n) begin
        state_next  = S_FIN;
        fin_st_next = ST_NOMEM;
      end else begin
        state_next = S_A_LOOP;
      end
      S_A_LOOP: if (flags.p_ge_n) begin
        state_next  = S_FIN;
        fin_st_next = ST_NOMEM;
      end else begin
        ctl.cmd    = C_RD_P;
        state_next = S_A_TAG;
      end
      S_A_TAG: begin
        ctl.cmd    = C_TAG;
        state_next = S_A_EVAL;
      end
      S_A_EVAL: if (flags.fit) begin
        if (flags.ext_bad) begin
          state_next  = S_FIN;
          fin_st_next = ST_CORRUPT;
        end else if (flags.whole) begin
          ctl.cmd     = C_WR_TAKE;
          state_next  = S_FIN;
          fin_st_next = ST_DONE;
        end else begin
          ctl.cmd    = C_BLK_REST;
          state_next = S_A_W1;
        end
      end else begin
        ctl.cmd    = C_ADV;
        state_next = S_A_LOOP;
      end
      S_A_W1: begin
        ctl.cmd    = C_WR_HEAD;
        state_next = S_A_W2;
      end
      S_A_W2: begin
        ctl.cmd    = C_WR_FOOT;
        state_next = S_A_W3;
      end
      S_A_W3: begin
        ctl.cmd    = C_BLK_USED;
        state_next = S_A_W4;
      end
      S_A_W4: begin
        ctl.cmd    = C_WR_HEAD;
        state_next = S_A_W5;
      end
      S_A_W5: begin
        ctl.cmd     = C_WR_FOOT;
        state_next  = S_FIN;
        fin_st_next = ST_DONE;
      end
      // release
      S_R_WAIT: if (!flags.div_busy) begin
        ctl.cmd    = C_SAVE_QA;
        state_next = S_R_U;
      end
      S_R_U: if (flags.rem_nz) begin
        state_next  = S_FIN;
        fin_st_next = ST_IGNORED;
      end else if (flags.u_lt_h || flags.hp_ge_n) begin
        state_next  = S_FIN;
        fin_st_next = ST_CORRUPT;
      end else begin
        ctl.cmd    = C_REL_INIT;
        state_next = S_R_RDH;
      end
      S_R_RDH: begin
        ctl.cmd    = C_RD_P;
        state_next = S_R_TAG;
      end
      S_R_TAG: begin
        ctl.cmd    = C_TAG;
        state_next = S_R_FT;
      end
      S_R_FT: if (flags.foot_bad) begin
        state_next  = S_FIN;
        fin_st_next = ST_CORRUPT;
      end else begin
        ctl.cmd    = C_RD_FOOT;
        state_next = S_R_CMP;
      end
      S_R_CMP: if (flags.tags_bad) begin
        state_next  = S_FIN;
        fin_st_next = ST_CORRUPT;
      end else if (flags.h_free) begin
        state_next  = S_FIN;
        fin_st_next = ST_IGNORED;
      end else begin
        ctl.cmd    = C_REL_HDR;
        state_next = S_R_PREV;
      end
      S_R_PREV: if (flags.p_zero) begin
        state_next = S_R_NEXT;
      end else if (flags.p_lt_f) begin
        state_next  = S_FIN;
        fin_st_next = ST_CORRUPT;
      end else begin
        ctl.cmd    = C_RD_PF;
        state_next = S_R_PFT;
      end
      S_R_PFT: if (flags.pf_bad) begin
        state_next  = S_FIN;
        fin_st_next = ST_CORRUPT;
      end else begin
        ctl.cmd    = C_REL_PH;
        state_next = S_R_PHR;
      end
      S_R_PHR: begin
        ctl.cmd    = C_RD_PF;
        state_next = S_R_PHT;
      end
      S_R_PHT: begin
        if (flags.rd_free) begin
          ctl.cmd = C_REL_MP;
        end
        state_next = S_R_NEXT;
      end
      S_R_NEXT: if (flags.nh_lt_n) begin
        ctl.cmd    = C_RD_NH;
        state_next = S_R_NHT;
      end else begin
        state_next = S_R_FIN;
      end
      S_R_NHT: begin
        if (flags.rd_free) begin
          ctl.cmd = C_REL_MN;
        end
        state_next = S_R_FIN;
      end
      S_R_FIN: if (flags.merge_bad) begin
        state_next  = S_FIN;
        fin_st_next = ST_CORRUPT;
      end else begin
        ctl.cmd    = C_BLK_MERGE;
        state_next = S_R_WH;
      end
      S_R_WH: begin
        ctl.cmd    = C_WR_HEAD;
        state_next = S_R_WF;
      end
      S_R_WF: begin
        ctl.cmd     = C_WR_FOOT;
        state_next  = S_FIN;
        fin_st_next = ST_DONE;
      end
      // check
      S_C_LOOP: if (flags.p_ge_n) begin
        state_next  = S_FIN;
        fin_st_next = ST_DONE;
      end else begin
        ctl.cmd    = C_RD_P;
        state_next = S_C_TAG;
      end
      S_C_TAG: begin
        ctl.cmd    = C_TAG;
        state_next = S_C_FT;
      end
      S_C_FT: if (flags.foot_bad) begin
        state_next  = S_FIN;
        fin_st_next = ST_CORRUPT;
      end else begin
        ctl.cmd    = C_RD_FOOT;
        state_next = S_C_CMP;
      end
      S_C_CMP: if (flags.tags_bad) begin
        state_next  = S_FIN;
        fin_st_next = ST_CORRUPT;
      end else begin
        ctl.cmd    = C_ADV;
        state_next = S_C_LOOP;
      end
      // result beat into the output register
      S_FIN: if (!out_valid || !out_stall) begin
        ctl.cmd    = C_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fin_st    <= ST_DONE;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      fin_st <= fin_st_next;
      if (ctl.cmd == C_FINISH) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/bthal_checker.sv =====
// port-level checks of the allocator, bound to the top level
module bthal_checker import bthal_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] payload_address,
  input status_t     status
);

  // held result beat keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_address) && $stable(status))
    else $error("stalled result beat changed");

  // one item in flight: busy right after an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // only a successful allocate returns an address
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> payload_address == 32'd0)
    else $error("address returned with a failing status");

  // idle and empty after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind boundary_tag_heap_allocator_top bthal_checker u_bthal_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .payload_address (payload_address),
  .status          (status)
);
